>>> rtl/qs_pkg.sv
// Shared types, constants and the arctangent table of the quaternion slerp block.
// Used by every cell module, the channel interfaces and the top level.
package qs_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_CELLS   = 31;
    localparam int DIV_BITS     = 48;
    localparam int ANG_W        = 34;
    localparam int CQ_SHL       = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
    localparam int CQ_SHR       = (2 * FRAC_BITS > 30) ? 2 * FRAC_BITS - 30 : 0;
    localparam int LIMIT_SHL    = 30 - FRAC_BITS;

    typedef logic signed [15:0]      comp_t;
    typedef logic signed [ANG_W-1:0] ang_t;

    localparam ang_t Q30_PI      = 34'sd3373259426;
    localparam ang_t Q30_HALF_PI = 34'sd1686629713;
    localparam ang_t Q30_GAIN    = 34'sd652032874;

    localparam logic [1:0] PATH_FIRST = 2'd0;
    localparam logic [1:0] PATH_AVG   = 2'd1;
    localparam logic [1:0] PATH_BLEND = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [1:0]       path;
        logic             neg;
        comp_t [3:0]      a;
        comp_t [3:0]      b;
        logic [15:0]      t;
        logic [29:0]      cq;
        logic [30:0]      s;
    } side_t;

    typedef struct packed {
        ang_t x;
        ang_t y;
        ang_t z;
    } cordic_t;

    typedef struct packed {
        logic [61:0] rem;
        logic [61:0] root;
    } sqrt_t;

    typedef struct packed {
        logic                neg;
        logic [31:0]         rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
    } div_t;

    function automatic ang_t atan_entry(logic [4:0] idx);
        ang_t v;
        case (idx)
            5'd0:    v = 34'sh3243F6A8;
            5'd1:    v = 34'sh1DAC6705;
            5'd2:    v = 34'sh0FADBAFC;
            5'd3:    v = 34'sh07F56EA6;
            5'd4:    v = 34'sh03FEAB76;
            5'd5:    v = 34'sh01FFD55B;
            5'd6:    v = 34'sh00FFFAAA;
            5'd7:    v = 34'sh007FFF55;
            5'd8:    v = 34'sh003FFFEA;
            5'd9:    v = 34'sh001FFFFD;
            5'd10:   v = 34'sh000FFFFF;
            5'd11:   v = 34'sh0007FFFF;
            5'd12:   v = 34'sh0003FFFF;
            5'd13:   v = 34'sh0001FFFF;
            5'd14:   v = 34'sh0000FFFF;
            5'd15:   v = 34'sh00007FFF;
            5'd16:   v = 34'sh00003FFF;
            5'd17:   v = 34'sh00001FFF;
            5'd18:   v = 34'sh00000FFF;
            5'd19:   v = 34'sh000007FF;
            5'd20:   v = 34'sh000003FF;
            5'd21:   v = 34'sh000001FF;
            5'd22:   v = 34'sh000000FF;
            5'd23:   v = 34'sh0000007F;
            5'd24:   v = 34'sh0000003F;
            5'd25:   v = 34'sh0000001F;
            5'd26:   v = 34'sh0000000F;
            5'd27:   v = 34'sh00000008;
            5'd28:   v = 34'sh00000004;
            5'd29:   v = 34'sh00000002;
            5'd30:   v = 34'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/qs_in_if.sv
// Input channel: two quaternions and a blend factor under valid/ready.
// Uses the component type of qs_pkg.
interface qs_in_if;
    logic          valid;
    logic          ready;
    qs_pkg::comp_t a_w;
    qs_pkg::comp_t a_x;
    qs_pkg::comp_t a_y;
    qs_pkg::comp_t a_z;
    qs_pkg::comp_t b_w;
    qs_pkg::comp_t b_x;
    qs_pkg::comp_t b_y;
    qs_pkg::comp_t b_z;
    logic [15:0]   blend;

    modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                    input ready);
    modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend,
                    output ready);
endinterface

>>> rtl/qs_out_if.sv
// Output channel: interpolated quaternion and the path code under valid/ready.
// Uses the component type of qs_pkg.
interface qs_out_if;
    logic          valid;
    logic          ready;
    qs_pkg::comp_t out_w;
    qs_pkg::comp_t out_x;
    qs_pkg::comp_t out_y;
    qs_pkg::comp_t out_z;
    logic [1:0]    path_taken;

    modport source (output valid, out_w, out_x, out_y, out_z, path_taken, input ready);
    modport sink   (input valid, out_w, out_x, out_y, out_z, path_taken, output ready);
endinterface

>>> rtl/quaternion_slerp.sv
// Quaternion slerp, fully pipelined: one item per cycle while the output is not stalled.
// The pipeline is made of the cell chains: 31 square root cells, 16 arctangent cells,
// 16 sine cells and 48 division cells, plus 10 stages of setup and output logic.
// The whole pipeline holds while a result waits on the output and ready is low.
// Reset clears every valid bit and sets limit_reg to 16; no clearing pass.
module quaternion_slerp (
    input  logic        clk,
    input  logic        rst_n,
    qs_in_if.sink       item_in,
    qs_out_if.source    item_out,
    input  logic        cfg_write_en,
    input  logic [14:0] cfg_write_data
);
    localparam int NSQ  = qs_pkg::SQRT_CELLS;
    localparam int NCR  = qs_pkg::CORDIC_STEPS;
    localparam int NDV  = qs_pkg::DIV_BITS;

    logic [14:0]    limit_reg;
    logic           en;

    qs_pkg::side_t  s0_side_reg, s0_side_next;
    logic signed [31:0] s0_prod_reg [4];
    qs_pkg::side_t  s1_side_reg, s1_side_next;
    qs_pkg::side_t  s2_side_reg;
    qs_pkg::sqrt_t  s2_data_reg, s2_data_next;
    qs_pkg::side_t  s3_side_reg, s3_side_next;
    qs_pkg::cordic_t s3_data_reg, s3_data_next;
    qs_pkg::side_t  s4_side_reg;
    qs_pkg::ang_t   s4_theta_reg, s4_theta_next;
    qs_pkg::side_t  s5_side_reg;
    qs_pkg::ang_t   s5_theta_reg;
    qs_pkg::ang_t   s5_ta_reg, s5_ta_next;
    qs_pkg::side_t  s6_side_reg;
    qs_pkg::cordic_t [1:0] s6_data_reg, s6_data_next;
    qs_pkg::side_t  s7_side_reg;
    qs_pkg::div_t [1:0] s7_data_reg, s7_data_next;
    qs_pkg::side_t  s8_side_reg;
    logic signed [64:0] s8_pa_reg [4];
    logic signed [64:0] s8_pb_reg [4];
    logic signed [64:0] s8_pa_next [4];
    logic signed [64:0] s8_pb_next [4];
    logic           out_valid_reg;
    logic [1:0]     out_path_reg, out_path_next;
    qs_pkg::comp_t [3:0] out_q_reg, out_q_next;

    qs_pkg::side_t  sq_side [NSQ+1];
    qs_pkg::sqrt_t  sq_data [NSQ+1];
    qs_pkg::side_t  at_side [NCR+1];
    qs_pkg::cordic_t at_data [NCR+1];
    qs_pkg::side_t  sn_side [NCR+1];
    qs_pkg::cordic_t [1:0] sn_data [NCR+1];
    qs_pkg::side_t  dv_side [NDV+1];
    qs_pkg::div_t [1:0] dv_data [NDV+1];

    logic signed [33:0] dot;
    logic [33:0]        mag;
    logic [59:0]        cq_sq;
    logic [30:0]        s_val;
    logic [30:0]        thr;
    logic signed [50:0] prod_t;
    qs_pkg::ang_t       ang [2];
    logic [33:0]        smag;
    logic [63:0]        dividend;
    logic signed [48:0] ratio [2];
    logic signed [65:0] acc;
    logic signed [65:0] rnd;
    logic signed [16:0] sum_ab;

    assign en            = !out_valid_reg || item_out.ready;
    assign item_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 15'd16;
        end
        else if (cfg_write_en)
        begin
            limit_reg <= cfg_write_data;
        end
    end

    // Input stage: capture and clamp the item, form the four products.
    always_comb
    begin
        s0_side_next       = '0;
        s0_side_next.valid = item_in.valid;
        s0_side_next.path  = qs_pkg::PATH_BLEND;
        s0_side_next.a     = {item_in.a_z, item_in.a_y, item_in.a_x, item_in.a_w};
        s0_side_next.b     = {item_in.b_z, item_in.b_y, item_in.b_x, item_in.b_w};
        s0_side_next.t     = (item_in.blend > 16'd32768) ? 16'd32768 : item_in.blend;
    end

    // Dot product, magnitude and the first-input test.
    always_comb
    begin
        dot = 34'(s0_prod_reg[0]) + 34'(s0_prod_reg[1])
            + 34'(s0_prod_reg[2]) + 34'(s0_prod_reg[3]);
        mag = dot[33] ? 34'(-dot) : 34'(dot);
        s1_side_next     = s0_side_reg;
        s1_side_next.neg = dot[33];
        s1_side_next.cq  = 30'((mag << qs_pkg::CQ_SHL) >> qs_pkg::CQ_SHR);
        if (mag >= (34'd1 << (2 * qs_pkg::FRAC_BITS)))
        begin
            s1_side_next.path = qs_pkg::PATH_FIRST;
        end
    end

    always_comb
    begin
        cq_sq             = 60'(s1_side_reg.cq) * 60'(s1_side_reg.cq);
        s2_data_next.rem  = (62'd1 << 60) - 62'(cq_sq);
        s2_data_next.root = '0;
    end

    assign sq_side[0] = s2_side_reg;
    assign sq_data[0] = s2_data_reg;

    for (genvar g = 0; g < NSQ; g++)
    begin : g_sqrt
        qs_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .idx      (5'(g)),
            .side_in  (sq_side[g]),
            .data_in  (sq_data[g]),
            .side_out (sq_side[g+1]),
            .data_out (sq_data[g+1])
        );
    end

    // Small-sine test and the start vector of the arctangent chain.
    always_comb
    begin
        s_val        = sq_data[NSQ].root[30:0];
        thr          = 31'(limit_reg) << qs_pkg::LIMIT_SHL;
        s3_side_next = sq_side[NSQ];
        s3_side_next.s = s_val;
        if (sq_side[NSQ].path != qs_pkg::PATH_FIRST && s_val < thr)
        begin
            s3_side_next.path = qs_pkg::PATH_AVG;
        end
        s3_data_next.x = qs_pkg::ang_t'(sq_side[NSQ].cq);
        s3_data_next.y = qs_pkg::ang_t'(s_val);
        s3_data_next.z = '0;
    end

    assign at_side[0] = s3_side_reg;
    assign at_data[0] = s3_data_reg;

    for (genvar g = 0; g < NCR; g++)
    begin : g_atan
        qs_atan_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .idx      (5'(g)),
            .side_in  (at_side[g]),
            .data_in  (at_data[g]),
            .side_out (at_side[g+1]),
            .data_out (at_data[g+1])
        );
    end

    assign s4_theta_next = at_side[NCR].neg ? qs_pkg::Q30_PI - at_data[NCR].z
                                            : at_data[NCR].z;

    always_comb
    begin
        prod_t     = 51'(s4_theta_reg) * 51'(signed'({1'b0, s4_side_reg.t}));
        s5_ta_next = qs_pkg::ang_t'((prod_t + 51'sd16384) >>> 15);
    end

    // Fold both angles into the first quadrant and seed the sine lanes.
    always_comb
    begin
        ang[0] = s5_theta_reg - s5_ta_reg;
        ang[1] = s5_ta_reg;
        for (int k = 0; k < 2; k++)
        begin
            if (ang[k] > qs_pkg::Q30_HALF_PI)
            begin
                ang[k] = qs_pkg::Q30_PI - ang[k];
            end
            s6_data_next[k].x = qs_pkg::Q30_GAIN;
            s6_data_next[k].y = '0;
            s6_data_next[k].z = ang[k];
        end
    end

    assign sn_side[0] = s6_side_reg;
    assign sn_data[0] = s6_data_reg;

    for (genvar g = 0; g < NCR; g++)
    begin : g_sin
        qs_sin_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .idx      (5'(g)),
            .side_in  (sn_side[g]),
            .data_in  (sn_data[g]),
            .side_out (sn_side[g+1]),
            .data_out (sn_data[g+1])
        );
    end

    always_comb
    begin
        smag     = '0;
        dividend = '0;
        for (int k = 0; k < 2; k++)
        begin
            smag     = sn_data[NCR][k].y[33] ? 34'(-sn_data[NCR][k].y)
                                             : 34'(sn_data[NCR][k].y);
            dividend = {smag[33:0], 30'd0};
            s7_data_next[k].neg = sn_data[NCR][k].y[33];
            s7_data_next[k].rem = {16'd0, dividend[63:NDV]};
            s7_data_next[k].num = dividend[NDV-1:0];
            s7_data_next[k].quo = '0;
        end
    end

    assign dv_side[0] = s7_side_reg;
    assign dv_data[0] = s7_data_reg;

    for (genvar g = 0; g < NDV; g++)
    begin : g_div
        qs_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .side_in  (dv_side[g]),
            .data_in  (dv_data[g]),
            .side_out (dv_side[g+1]),
            .data_out (dv_data[g+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            ratio[k] = dv_data[NDV][k].neg ? -signed'({1'b0, dv_data[NDV][k].quo})
                                           : signed'({1'b0, dv_data[NDV][k].quo});
        end
        for (int k = 0; k < 4; k++)
        begin
            s8_pa_next[k] = 65'(dv_side[NDV].a[k]) * 65'(ratio[0]);
            s8_pb_next[k] = 65'(dv_side[NDV].b[k]) * 65'(ratio[1]);
        end
    end

    // Output selection: first input, floor average or rounded, saturated blend.
    always_comb
    begin
        out_path_next = s8_side_reg.path;
        acc    = '0;
        rnd    = '0;
        sum_ab = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc    = 66'(s8_pa_reg[k]) + 66'(s8_pb_reg[k]) + (66'sd1 <<< 29);
            rnd    = acc >>> 30;
            sum_ab = 17'(s8_side_reg.a[k]) + 17'(s8_side_reg.b[k]);
            case (s8_side_reg.path)
                qs_pkg::PATH_FIRST: out_q_next[k] = s8_side_reg.a[k];
                qs_pkg::PATH_AVG:   out_q_next[k] = 16'(sum_ab >>> 1);
                default:
                begin
                    if (rnd > 66'sd32767)
                    begin
                        out_q_next[k] = 16'sh7FFF;
                    end
                    else if (rnd < -66'sd32768)
                    begin
                        out_q_next[k] = 16'sh8000;
                    end
                    else
                    begin
                        out_q_next[k] = 16'(rnd);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_side_reg   <= '0;
            s1_side_reg   <= '0;
            s2_side_reg   <= '0;
            s3_side_reg   <= '0;
            s4_side_reg   <= '0;
            s5_side_reg   <= '0;
            s6_side_reg   <= '0;
            s7_side_reg   <= '0;
            s8_side_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_side_reg   <= s0_side_next;
            s1_side_reg   <= s1_side_next;
            s2_side_reg   <= s1_side_reg;
            s3_side_reg   <= s3_side_next;
            s4_side_reg   <= at_side[NCR];
            s5_side_reg   <= s4_side_reg;
            s6_side_reg   <= s5_side_reg;
            s7_side_reg   <= sn_side[NCR];
            s8_side_reg   <= dv_side[NDV];
            out_valid_reg <= s8_side_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_prod_reg[0] <= 32'(item_in.a_w) * 32'(item_in.b_w);
            s0_prod_reg[1] <= 32'(item_in.a_x) * 32'(item_in.b_x);
            s0_prod_reg[2] <= 32'(item_in.a_y) * 32'(item_in.b_y);
            s0_prod_reg[3] <= 32'(item_in.a_z) * 32'(item_in.b_z);
            s2_data_reg    <= s2_data_next;
            s3_data_reg    <= s3_data_next;
            s4_theta_reg   <= s4_theta_next;
            s5_theta_reg   <= s4_theta_reg;
            s5_ta_reg      <= s5_ta_next;
            s6_data_reg    <= s6_data_next;
            s7_data_reg    <= s7_data_next;
            s8_pa_reg      <= s8_pa_next;
            s8_pb_reg      <= s8_pb_next;
            out_path_reg   <= out_path_next;
            out_q_reg      <= out_q_next;
        end
    end

    assign item_out.valid      = out_valid_reg;
    assign item_out.out_w      = out_q_reg[0];
    assign item_out.out_x      = out_q_reg[1];
    assign item_out.out_y      = out_q_reg[2];
    assign item_out.out_z      = out_q_reg[3];
    assign item_out.path_taken = out_path_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(s0_side_reg) && $stable(s8_side_reg))
        else $error("pipeline moved while the output was stalled");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready) |=> s0_side_reg.valid)
        else $error("accepted item did not enter the first stage");

    a_path_code: assert property (@(posedge clk) disable iff (!rst_n)
        item_out.valid |-> (item_out.path_taken == qs_pkg::PATH_FIRST
                            || item_out.path_taken == qs_pkg::PATH_AVG
                            || item_out.path_taken == qs_pkg::PATH_BLEND))
        else $error("result carries an undefined path code");
endmodule

>>> rtl/qs_sqrt_cell.sv
// One cell of the square root chain: resolves one result bit per cell.
// Depends on qs_pkg.
module qs_sqrt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [4:0]    idx,
    input  qs_pkg::side_t side_in,
    input  qs_pkg::sqrt_t data_in,
    output qs_pkg::side_t side_out,
    output qs_pkg::sqrt_t data_out
);
    qs_pkg::side_t side_reg;
    qs_pkg::sqrt_t data_reg;
    qs_pkg::sqrt_t data_next;
    logic [5:0]    shamt;
    logic [61:0]   bitv;
    logic [61:0]   trial;

    always_comb
    begin
        shamt = 6'(7'd60 - {1'b0, idx, 1'b0});
        bitv  = 62'd1 << shamt;
        trial = data_in.root + bitv;
        if (data_in.rem >= trial)
        begin
            data_next.rem  = data_in.rem - trial;
            data_next.root = (data_in.root >> 1) + bitv;
        end
        else
        begin
            data_next.rem  = data_in.rem;
            data_next.root = data_in.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign side_out = side_reg;
    assign data_out = data_reg;
endmodule

>>> rtl/qs_atan_cell.sv
// One vectoring CORDIC cell: one micro-rotation toward the x axis per cell.
// Depends on qs_pkg for the angle table.
module qs_atan_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic [4:0]      idx,
    input  qs_pkg::side_t   side_in,
    input  qs_pkg::cordic_t data_in,
    output qs_pkg::side_t   side_out,
    output qs_pkg::cordic_t data_out
);
    qs_pkg::side_t   side_reg;
    qs_pkg::cordic_t data_reg;
    qs_pkg::cordic_t data_next;
    qs_pkg::ang_t    x;
    qs_pkg::ang_t    y;
    qs_pkg::ang_t    z;
    qs_pkg::ang_t    dx;
    qs_pkg::ang_t    dy;
    qs_pkg::ang_t    step;

    always_comb
    begin
        x    = data_in.x;
        y    = data_in.y;
        z    = data_in.z;
        dx   = y >>> idx;
        dy   = x >>> idx;
        step = qs_pkg::atan_entry(idx);
        if (y > 0)
        begin
            data_next.x = x + dx;
            data_next.y = y - dy;
            data_next.z = z + step;
        end
        else
        begin
            data_next.x = x - dx;
            data_next.y = y + dy;
            data_next.z = z - step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign side_out = side_reg;
    assign data_out = data_reg;
endmodule

>>> rtl/qs_sin_cell.sv
// One rotation CORDIC cell with two lanes, one for each sine of the blend.
// Depends on qs_pkg for the angle table.
module qs_sin_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [4:0]            idx,
    input  qs_pkg::side_t         side_in,
    input  qs_pkg::cordic_t [1:0] data_in,
    output qs_pkg::side_t         side_out,
    output qs_pkg::cordic_t [1:0] data_out
);
    qs_pkg::side_t         side_reg;
    qs_pkg::cordic_t [1:0] data_reg;
    qs_pkg::cordic_t [1:0] data_next;
    qs_pkg::ang_t          x;
    qs_pkg::ang_t          y;
    qs_pkg::ang_t          z;
    qs_pkg::ang_t          dx;
    qs_pkg::ang_t          dy;
    qs_pkg::ang_t          step;

    always_comb
    begin
        step = qs_pkg::atan_entry(idx);
        x    = '0;
        y    = '0;
        z    = '0;
        dx   = '0;
        dy   = '0;
        for (int k = 0; k < 2; k++)
        begin
            x  = data_in[k].x;
            y  = data_in[k].y;
            z  = data_in[k].z;
            dx = y >>> idx;
            dy = x >>> idx;
            if (z >= 0)
            begin
                data_next[k].x = x - dx;
                data_next[k].y = y + dy;
                data_next[k].z = z - step;
            end
            else
            begin
                data_next[k].x = x + dx;
                data_next[k].y = y - dy;
                data_next[k].z = z + step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign side_out = side_reg;
    assign data_out = data_reg;
endmodule

>>> rtl/qs_div_cell.sv
// One restoring division cell with two lanes: one quotient bit per lane and cell.
// The divisor is the sine of the angle carried in the side band. Depends on qs_pkg.
module qs_div_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  qs_pkg::side_t      side_in,
    input  qs_pkg::div_t [1:0] data_in,
    output qs_pkg::side_t      side_out,
    output qs_pkg::div_t [1:0] data_out
);
    qs_pkg::side_t      side_reg;
    qs_pkg::div_t [1:0] data_reg;
    qs_pkg::div_t [1:0] data_next;
    logic [31:0]        trial;
    logic               hit;

    always_comb
    begin
        trial = '0;
        hit   = 1'b0;
        for (int k = 0; k < 2; k++)
        begin
            trial = {data_in[k].rem[30:0], data_in[k].num[qs_pkg::DIV_BITS-1]};
            hit   = trial >= {1'b0, side_in.s};
            data_next[k].neg = data_in[k].neg;
            data_next[k].rem = hit ? trial - {1'b0, side_in.s} : trial;
            data_next[k].num = data_in[k].num << 1;
            data_next[k].quo = {data_in[k].quo[qs_pkg::DIV_BITS-2:0], hit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign side_out = side_reg;
    assign data_out = data_reg;
endmodule

>>> verif/tb_quaternion_slerp.sv
// Testbench for quaternion_slerp: directed table and random items, checked against
// fixed expected results or a fixed-point slerp predictor, under random idling and
// a long output hold-off. Depends on qs_pkg, qs_in_if, qs_out_if and the quaternion_slerp RTL.
module tb_quaternion_slerp;

    localparam int LATENCY = 121;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
        logic [15:0]        blend;
    } slerp_in_t;

    typedef struct {
        logic signed [15:0] q [4];
        logic [1:0]         path;
    } slerp_out_t;

    typedef struct {
        slerp_in_t  item;
        logic       known;
        slerp_out_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic [14:0] cfg_write_data;

    qs_in_if  in_ch();
    qs_out_if out_ch();

    quaternion_slerp u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_in        (in_ch.sink),
        .item_out       (out_ch.source),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    slerp_out_t expected_q [$];
    logic [14:0] sine_limit;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    int mismatches;
    int cycles;
    bit failed;
    dir_row_t rows [$];

    localparam logic signed [63:0] ATAN_Q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int n);
        return v >>> n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic signed [63:0] vector_angle(logic signed [63:0] x,
                                                        logic signed [63:0] y);
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        z = 0;
        for (int i = 0; i < qs_pkg::CORDIC_STEPS; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0)
            begin
                x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
            end
            else
            begin
                x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [63:0] rotate_sine(logic signed [63:0] ang);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        x = 64'(qs_pkg::Q30_GAIN);
        y = 0;
        if (ang > 64'(qs_pkg::Q30_HALF_PI))
            ang = 64'(qs_pkg::Q30_PI) - ang;
        z = ang;
        for (int i = 0; i < qs_pkg::CORDIC_STEPS; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - ATAN_Q30[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + ATAN_Q30[i];
            end
        end
        return y;
    endfunction

    function automatic logic signed [63:0] sine_ratio(logic signed [63:0] sn, logic [63:0] s);
        logic [63:0] mag;
        mag = (sn < 0) ? -sn : sn;
        mag = (mag << 30) / s;
        return (sn < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [15:0] clamp16(logic signed [63:0] v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic slerp_out_t predict_slerp(slerp_in_t it, logic [14:0] lim);
        slerp_out_t r;
        logic signed [63:0] dot;
        logic signed [63:0] theta;
        logic signed [63:0] ta;
        logic signed [63:0] r1;
        logic signed [63:0] r2;
        logic signed [63:0] acc;
        logic [63:0] mag;
        logic [63:0] cq;
        logic [63:0] s;
        logic [63:0] t;
        dot = 0;
        for (int k = 0; k < 4; k++)
            dot = dot + 64'(it.a[k]) * 64'(it.b[k]);
        t = (it.blend > 16'd32768) ? 64'd32768 : 64'(it.blend);
        mag = (dot < 0) ? -dot : dot;
        if (mag >= (64'd1 << (2 * qs_pkg::FRAC_BITS)))
        begin
            for (int k = 0; k < 4; k++)
                r.q[k] = it.a[k];
            r.path = qs_pkg::PATH_FIRST;
            return r;
        end
        cq = (mag << qs_pkg::CQ_SHL) >> qs_pkg::CQ_SHR;
        s = int_sqrt((64'd1 << 60) - cq * cq);
        if (s < (64'(lim) << qs_pkg::LIMIT_SHL))
        begin
            for (int k = 0; k < 4; k++)
                r.q[k] = clamp16(shr_floor(64'(it.a[k]) + 64'(it.b[k]), 1));
            r.path = qs_pkg::PATH_AVG;
            return r;
        end
        theta = vector_angle($signed(cq), $signed(s));
        if (dot < 0)
            theta = 64'(qs_pkg::Q30_PI) - theta;
        ta = (theta * $signed(t) + (64'sd1 << 14)) >>> 15;
        r1 = sine_ratio(rotate_sine(theta - ta), s);
        r2 = sine_ratio(rotate_sine(ta), s);
        for (int k = 0; k < 4; k++)
        begin
            acc = 64'(it.a[k]) * r1 + 64'(it.b[k]) * r2;
            r.q[k] = clamp16(shr_floor(acc + (64'sd1 << 29), 30));
        end
        r.path = qs_pkg::PATH_BLEND;
        return r;
    endfunction

    function automatic slerp_in_t make_item(int aw, int ax, int ay, int az,
                                            int bw, int bx, int by, int bz, int t);
        slerp_in_t it;
        it.a[0] = 16'(aw); it.a[1] = 16'(ax); it.a[2] = 16'(ay); it.a[3] = 16'(az);
        it.b[0] = 16'(bw); it.b[1] = 16'(bx); it.b[2] = 16'(by); it.b[3] = 16'(bz);
        it.blend = 16'(t);
        return it;
    endfunction

    function automatic slerp_in_t random_item();
        slerp_in_t it;
        int mode;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 4; k++)
        begin
            if (mode < 6)
            begin
                // Components in [-8192, 8191], within half the unit scale, so that the blend path is taken often.
                it.a[k] = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
                it.b[k] = $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
            end
            else
            begin
                it.a[k] = 16'($urandom);
                it.b[k] = 16'($urandom);
            end
        end
        if (mode == 6)
            for (int k = 0; k < 4; k++)
                it.b[k] = it.a[k] + $signed(16'($urandom_range(0, 6))) - 16'sd3;
        if (mode == 7)
            for (int k = 0; k < 4; k++)
                it.b[k] = -it.a[k];
        it.blend = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 32768));
        return it;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("quaternion_slerp test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        slerp_out_t exp_r;
        bit bad;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: path %0d", out_ch.path_taken);
            end
            else
            begin
                exp_r = expected_q.pop_front();
                bad = (out_ch.out_w !== exp_r.q[0]) || (out_ch.out_x !== exp_r.q[1])
                    || (out_ch.out_y !== exp_r.q[2]) || (out_ch.out_z !== exp_r.q[3])
                    || (out_ch.path_taken !== exp_r.path);
                if (bad)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d p%0d, got %0d %0d %0d %0d p%0d",
                                 exp_r.q[0], exp_r.q[1], exp_r.q[2], exp_r.q[3], exp_r.path,
                                 out_ch.out_w, out_ch.out_x, out_ch.out_y, out_ch.out_z,
                                 out_ch.path_taken);
                end
            end
        end
    end

    task automatic send_item(slerp_in_t it, bit known, slerp_out_t res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.a_w <= it.a[0]; in_ch.a_x <= it.a[1];
        in_ch.a_y <= it.a[2]; in_ch.a_z <= it.a[3];
        in_ch.b_w <= it.b[0]; in_ch.b_x <= it.b[1];
        in_ch.b_y <= it.b[2]; in_ch.b_z <= it.b[3];
        in_ch.blend <= it.blend;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        expected_q.push_back(known ? res : predict_slerp(it, sine_limit));
    endtask

    task automatic write_limit(logic [14:0] v);
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sine_limit = v;
    endtask

    task automatic add_row(slerp_in_t it, bit known, int w, int x, int y, int z, int p);
        dir_row_t r;
        r.item = it;
        r.known = known;
        r.res.q[0] = 16'(w); r.res.q[1] = 16'(x); r.res.q[2] = 16'(y); r.res.q[3] = 16'(z);
        r.res.path = 2'(p);
        rows.push_back(r);
    endtask

    initial
    begin
        slerp_out_t none;
        logic [14:0] limits [6];
        rst_n = 1'b0;
        cycles = 0;
        mismatches = 0;
        failed = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sine_limit = 15'd16;
        cfg_write_en = 1'b0;
        cfg_write_data = '0;
        in_ch.valid = 1'b0;
        in_ch.a_w = '0; in_ch.a_x = '0; in_ch.a_y = '0; in_ch.a_z = '0;
        in_ch.b_w = '0; in_ch.b_x = '0; in_ch.b_y = '0; in_ch.b_z = '0;
        in_ch.blend = '0;
        out_ch.ready = 1'b0;
        none = '{default: 0};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(make_item(16384, 0, 0, 0, 16384, 0, 0, 0, 16384),
                1, 16384, 0, 0, 0, qs_pkg::PATH_FIRST);
        add_row(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0),
                1, -32768, -32768, -32768, -32768, qs_pkg::PATH_FIRST);
        add_row(make_item(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 65535),
                1, 32767, 32767, 32767, 32767, qs_pkg::PATH_FIRST);
        add_row(make_item(0, 0, 0, 0, 0, 0, 0, 0, 16384), 0, 0, 0, 0, 0, 0);
        add_row(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 0), 0, 0, 0, 0, 0, 0);
        add_row(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 32768), 0, 0, 0, 0, 0, 0);
        add_row(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 16384), 0, 0, 0, 0, 0, 0);
        add_row(make_item(16384, 0, 0, 0, 0, 16384, 0, 0, 65535), 0, 0, 0, 0, 0, 0);
        add_row(make_item(16383, 0, 0, 0, 16383, 0, 0, 0, 16384), 0, 0, 0, 0, 0, 0);
        add_row(make_item(16383, 0, 0, 0, 16384, 1, 0, 0, 20000), 0, 0, 0, 0, 0, 0);
        add_row(make_item(16383, 0, 0, 0, -16383, 0, 0, 0, 8192), 0, 0, 0, 0, 0, 0);
        add_row(make_item(11585, 11585, 0, 0, -11585, 11585, 0, 0, 24576), 0, 0, 0, 0, 0, 0);
        add_row(make_item(8192, -8192, 8192, -8192, -8192, 8192, 0, 8192, 1), 0, 0, 0, 0, 0, 0);
        add_row(make_item(128, 64, -32, 16, 100, -50, 25, 12, 32767), 0, 0, 0, 0, 0, 0);

        for (int i = 0; i < rows.size(); i++)
            send_item(rows[i].item, rows[i].known, rows[i].res);

        limits = '{15'd0, 15'd16384, 15'd32767, 15'd2000, 15'd1, 15'd16};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_limit(limits[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            if (ph == 0)
                hold_cycles <= 300;
            for (int n = 0; n < 135; n++)
                send_item(random_item(), 0, none);
            in_ch.valid <= 1'b0;
        end

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (!failed)
            $display("quaternion_slerp test passed");
        else
            $display("quaternion_slerp test failed");
        $finish;
    end
endmodule
